/* sv/hcm_pkg.sv */
// Shared types and constants for the heat/cool mode selector.
`default_nettype none
package hcm_pkg;

  localparam int DEMAND_W = 15;
  localparam int TIME_W   = 32;
  localparam int DUTY_W   = 14;
  localparam int MODE_W   = 2;
  localparam int CFG_IDX_W = 1;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_IDLE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HEAT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COOL = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ON  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_OFF = 1'd1;

  localparam logic [TIME_W-1:0] MIN_ON_RESET  = 32'd180000;
  localparam logic [TIME_W-1:0] MIN_OFF_RESET = 32'd300000;

  localparam logic signed [DEMAND_W-1:0] DEAD_BAND_POS = 15'sd100;
  localparam logic signed [DEMAND_W-1:0] DEAD_BAND_NEG = -15'sd100;
  localparam logic [DUTY_W-1:0]          DUTY_FULL     = 14'd10000;

  typedef struct packed {
    logic [TIME_W-1:0] min_on_ms;
    logic [TIME_W-1:0] min_off_ms;
  } hcm_cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DUTY_W-1:0] heater_duty;
    logic [DUTY_W-1:0] cooler_duty;
    logic              cooler_active;
    logic              held;
  } hcm_result_t;

endpackage
`default_nettype wire

/* sv/hcm_cfg_regs.sv */
// Configuration registers: minimum cooler on and off times.
`default_nettype none
module hcm_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [hcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hcm_pkg::TIME_W-1:0]     cfg_data,
  output hcm_pkg::hcm_cfg_t                   cfg
);
  import hcm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_on_ms  <= MIN_ON_RESET;
      cfg.min_off_ms <= MIN_OFF_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MIN_ON:  cfg.min_on_ms  <= cfg_data;
        REG_MIN_OFF: cfg.min_off_ms <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* sv/hcm_core.sv */
// Mode decision with compressor guard timers and the controller state.
`default_nettype none
module hcm_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 step,
  input  wire logic signed [hcm_pkg::DEMAND_W-1:0]  demand,
  input  wire logic [hcm_pkg::TIME_W-1:0]           now_ms,
  input  wire hcm_pkg::hcm_cfg_t                    cfg,
  output hcm_pkg::hcm_result_t                      result
);
  import hcm_pkg::*;

  logic [MODE_W-1:0] mode_reg, mode_reg_next;
  logic              cooler_running, cooler_running_next;
  logic [TIME_W-1:0] cool_start_ms, cool_start_ms_next;
  logic [TIME_W-1:0] cool_stop_ms, cool_stop_ms_next;
  logic [DUTY_W-1:0] heater_level, heater_level_next;
  logic [DUTY_W-1:0] cooler_level, cooler_level_next;
  logic              held;

  logic [TIME_W-1:0]       on_elapsed, off_elapsed;
  logic                    on_block, off_block;
  logic signed [DEMAND_W:0] demand_neg;
  logic [DUTY_W-1:0]       heat_sat, cool_sat;

  assign on_elapsed  = now_ms - cool_start_ms;
  assign off_elapsed = now_ms - cool_stop_ms;
  assign on_block    = cooler_running && (on_elapsed < cfg.min_on_ms);
  assign off_block   = !cooler_running && (cool_stop_ms != '0) &&
                       (off_elapsed < cfg.min_off_ms);

  // Both saturations only matter when the demand is past the dead band,
  // so the source value is positive there.
  assign demand_neg = -{demand[DEMAND_W-1], demand};
  assign heat_sat   = (demand > $signed({1'b0, DUTY_FULL})) ? DUTY_FULL
                                                            : demand[DUTY_W-1:0];
  assign cool_sat   = (demand_neg > $signed({2'b00, DUTY_FULL})) ? DUTY_FULL
                                                                 : demand_neg[DUTY_W-1:0];

  always_comb begin
    mode_reg_next       = mode_reg;
    cooler_running_next = cooler_running;
    cool_start_ms_next  = cool_start_ms;
    cool_stop_ms_next   = cool_stop_ms;
    heater_level_next   = heater_level;
    cooler_level_next   = cooler_level;
    held                = 1'b0;

    if (demand > DEAD_BAND_POS) begin
      if (on_block) begin
        held = 1'b1;
      end else begin
        if (cooler_running) begin
          cooler_running_next = 1'b0;
          cooler_level_next   = '0;
          cool_start_ms_next  = '0;
          if (cool_stop_ms == '0) cool_stop_ms_next = now_ms;
        end
        heater_level_next = heat_sat;
        mode_reg_next     = MODE_HEAT;
      end
    end else if (demand < DEAD_BAND_NEG) begin
      if (off_block) begin
        held = 1'b1;
      end else begin
        heater_level_next = '0;
        if (cool_start_ms == '0) begin
          cool_start_ms_next = now_ms;
          cool_stop_ms_next  = '0;
        end
        cooler_level_next   = cool_sat;
        cooler_running_next = 1'b1;
        mode_reg_next       = MODE_COOL;
      end
    end else begin
      heater_level_next = '0;
      if (on_block) begin
        held = 1'b1;
      end else begin
        if (cooler_running) begin
          cooler_running_next = 1'b0;
          cooler_level_next   = '0;
          cool_start_ms_next  = '0;
          if (cool_stop_ms == '0) cool_stop_ms_next = now_ms;
        end
        mode_reg_next = MODE_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg       <= MODE_IDLE;
      cooler_running <= 1'b0;
      cool_start_ms  <= '0;
      cool_stop_ms   <= '0;
      heater_level   <= '0;
      cooler_level   <= '0;
    end else if (step) begin
      mode_reg       <= mode_reg_next;
      cooler_running <= cooler_running_next;
      cool_start_ms  <= cool_start_ms_next;
      cool_stop_ms   <= cool_stop_ms_next;
      heater_level   <= heater_level_next;
      cooler_level   <= cooler_level_next;
    end
  end

  assign result.mode          = mode_reg_next;
  assign result.heater_duty   = heater_level_next;
  assign result.cooler_duty   = cooler_level_next;
  assign result.cooler_active = cooler_running_next;
  assign result.held          = held;

`ifndef NO_ASSERTIONS
  a_run_is_cool: assert property (@(posedge clk) disable iff (rst)
    cooler_running |-> mode_reg == MODE_COOL)
    else $error("cooler running outside cooling mode");

  a_stopped_no_drive: assert property (@(posedge clk) disable iff (rst)
    !cooler_running |-> cooler_level == '0)
    else $error("stopped cooler still has drive level");

  a_heat_only_heating: assert property (@(posedge clk) disable iff (rst)
    heater_level != '0 |-> mode_reg == MODE_HEAT)
    else $error("heater drive outside heating mode");

  a_held_keeps_state: assert property (@(posedge clk) disable iff (rst)
    step && held |=> $stable(mode_reg) && $stable(cooler_running) &&
                     $stable(cool_start_ms) && $stable(cool_stop_ms))
    else $error("held step changed guard state");
`endif

endmodule
`default_nettype wire

/* sv/heat_cool_mode_with_compressor_guard_unit.sv */
// Top level: heat/cool mode selector with compressor anti-short-cycle guard.
//
// Item channel: item_valid/item_stall carry demand (signed, 0.01 % units)
// and now_ms (free-running millisecond time). Result channel:
// result_valid/result_stall carry mode, heater_duty, cooler_duty,
// cooler_active and held. An item moves when valid is high and stall low.
// Config port: cfg_write with cfg_index 0 (min_on_ms) or 1 (min_off_ms)
// and cfg_data; write only while no item is in flight.
// Path: an item taken is captured in the input register, decided from it
// combinationally and written to the result register when it advances.
// Throughput: one item per cycle unless stalled; decision and guard-state
// update happen in the same cycle (one 32-bit subtract and compare per
// timer), so the next item always sees the state left by the previous one.
// Stall: when result_stall holds a pending result, the input register
// keeps its item and item_stall rises while it is full; a free input
// register still takes one item, so the two sides are decoupled by a stage.
// Reset (rst, synchronous): both stages empty, mode idle, cooler stopped,
// timestamps not set, levels zero, min_on_ms 180000, min_off_ms 300000.
`default_nettype none
module heat_cool_mode_with_compressor_guard_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 item_valid,
  output logic                                      item_stall,
  input  wire logic signed [hcm_pkg::DEMAND_W-1:0]  demand,
  input  wire logic [hcm_pkg::TIME_W-1:0]           now_ms,
  output logic                                      result_valid,
  input  wire logic                                 result_stall,
  output logic [hcm_pkg::MODE_W-1:0]                mode,
  output logic [hcm_pkg::DUTY_W-1:0]                heater_duty,
  output logic [hcm_pkg::DUTY_W-1:0]                cooler_duty,
  output logic                                      cooler_active,
  output logic                                      held,
  input  wire logic                                 cfg_write,
  input  wire logic [hcm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [hcm_pkg::TIME_W-1:0]           cfg_data
);
  import hcm_pkg::*;

  hcm_cfg_t    cfg;
  hcm_result_t result;

  // input stage
  logic                       in_vld;
  logic signed [DEMAND_W-1:0] demand_q;
  logic [TIME_W-1:0]          now_q;

  logic advance;  // input stage item decided and moved to result register
  logic take;     // new item accepted into input stage

  assign advance    = in_vld && (!result_valid || !result_stall);
  assign item_stall = in_vld && !advance;
  assign take       = item_valid && !item_stall;

  hcm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hcm_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .demand (demand_q),
    .now_ms (now_q),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (take) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      demand_q <= demand;
      now_q    <= now_ms;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mode          <= result.mode;
      heater_duty   <= result.heater_duty;
      cooler_duty   <= result.cooler_duty;
      cooler_active <= result.cooler_active;
      held          <= result.held;
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_only_full: assert property (@(posedge clk)
    item_stall |-> in_vld)
    else $error("input stalled with empty input stage");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !in_vld)
    else $error("pipeline not empty after reset");

  a_advance_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid)
    else $error("decided item did not reach result register");
`endif

endmodule
`default_nettype wire
